FILE: rtl/core/mru_type_list_core_macros.svh
// Assertion macros for the MRU type list core.
// The checks sample on clk and are disabled while rst_n is low.
`ifndef MRU_TYPE_LIST_CORE_MACROS_SVH
`define MRU_TYPE_LIST_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define MTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTL_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |-> post) else $error(msg);
`else
`define MTL_ASSERT(lbl, prop, msg)
`define MTL_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/core/mtl_pkg.sv
package mtl_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int TYPE_LIMIT = 64;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] MODE_TOUCH  = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] item_type;
    logic [4:0] position;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       was_present;
    logic       evicted_valid;
    logic [7:0] evicted_type;
    logic [7:0] read_type;
    logic [5:0] entry_total;
    logic       changed;
  } out_t;

  // one write per cycle into the entry store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

endpackage

FILE: rtl/core/mru_type_list_core.sv
// MRU type list core: keeps a most-recently-used list of distinct type codes.
// Input channel: present in_req and raise start; the transaction is taken on a
// clock edge where start is high and busy is low. busy stays high until the
// result has been produced.
// mode touch moves a present type to the front or inserts an absent one
// (dropping the tail when the list is full), delete removes a type and closes
// the gap, read returns the entry at in_req.position (zero beyond the count).
// Result channel: out_res is valid for exactly one cycle with out_valid high.
// The receiver cannot stall, so it must take the result in that cycle.
// One compare unit walks the list one entry per cycle, then the entries that
// must move (in front of the hit or insert point for touch, behind the hit for
// delete) are moved one per cycle through the single store write port. A read,
// a refused or an unused-mode transaction passes only the done state and the
// output register; touch and delete also pass the search and move states,
// longest for an insert into a full list or a touch that hits the last entry.
// A new transaction can be accepted at the edge that takes the result, so the
// block works on one transaction at a time.
// Reset (rst_n low, synchronous) empties the list; no result is pending after.
module mru_type_list_core
  import mtl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_req,
  output logic out_valid,
  output out_t out_res
);

  wr_t              wr;
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rdata;
  logic             done;
  out_t             res;

  logic out_valid_r;
  out_t out_res_r;

  mtl_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  mtl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .busy   (busy),
    .wr     (wr),
    .raddr  (raddr),
    .rdata  (rdata),
    .done   (done),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/core/mtl_store.sv
module mtl_store
  import mtl_pkg::*;
(
  input  logic             clk,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] entries_r [LIST_DEPTH];

  // slots at or beyond the count are never read as data, so no reset
  always_ff @(posedge clk) begin
    if (wr.we) begin
      entries_r[wr.addr] <= wr.data;
    end
  end

  assign rdata = entries_r[raddr];

endmodule

FILE: rtl/core/mtl_ctrl.sv
`include "mru_type_list_core_macros.svh"

module mtl_ctrl
  import mtl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_t              in_req,
  output logic             busy,
  output wr_t              wr,
  output logic [IDX_W-1:0] raddr,
  input  logic [7:0]       rdata,
  output logic             done,
  output out_t             res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FRONT,
    ST_FSHIFT,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  out_t             res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] sh_r, sh_nxt;

  logic in_oor;
  logic req_oor;
  logic hit;
  logic last;

  assign in_oor  = (9'(in_req.item_type) >= 9'(TYPE_LIMIT));
  assign req_oor = (9'(req_r.item_type) >= 9'(TYPE_LIMIT));
  // shared compare unit: one stored entry against the requested type per cycle
  assign hit  = (rdata == req_r.item_type);
  assign last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    wr        = '0;
    raddr     = idx_r;
    done      = 1'b0;
    res       = res_r;
    case (state_r)
      ST_IDLE: begin
        raddr = IDX_W'(in_req.position);
        if (start) begin
          req_nxt = in_req;
          res_nxt = '0;
          idx_nxt = '0;
          case (in_req.mode)
            MODE_TOUCH: begin
              if (in_oor) begin
                res_nxt.status = STATUS_RANGE;
                state_nxt      = ST_DONE;
              end else if (cnt_r == '0) begin
                res_nxt.changed = 1'b1;
                cnt_nxt         = CNT_W'(1);
                state_nxt       = ST_FRONT;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            MODE_DELETE: begin
              if (in_oor) begin
                res_nxt.status = STATUS_RANGE;
                state_nxt      = ST_DONE;
              end else if (cnt_r == '0) begin
                res_nxt.status = STATUS_EMPTY;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            MODE_READ: begin
              if (32'(in_req.position) < 32'(cnt_r)) begin
                res_nxt.read_type = rdata;
              end
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        raddr = idx_r;
        if (hit) begin
          res_nxt.was_present = 1'b1;
          sh_nxt              = idx_r;
          if (req_r.mode == MODE_DELETE) begin
            res_nxt.changed = 1'b1;
            state_nxt       = last ? ST_CLEAR : ST_FSHIFT;
          end else if (idx_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            res_nxt.changed = 1'b1;
            state_nxt       = ST_SHIFT;
          end
        end else if (last) begin
          if (req_r.mode == MODE_DELETE) begin
            state_nxt = ST_DONE;
          end else begin
            res_nxt.changed = 1'b1;
            state_nxt       = ST_SHIFT;
            if (cnt_r == CNT_W'(LIST_DEPTH)) begin
              // full list: the tail entry read on this last compare falls off
              res_nxt.evicted_valid = 1'b1;
              res_nxt.evicted_type  = rdata;
              sh_nxt                = IDX_W'(LIST_DEPTH - 1);
            end else begin
              sh_nxt  = IDX_W'(cnt_r);
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        raddr = sh_r - IDX_W'(1);
        wr    = '{we: 1'b1, addr: sh_r, data: rdata};
        if (sh_r == IDX_W'(1)) begin
          state_nxt = ST_FRONT;
        end else begin
          sh_nxt = sh_r - IDX_W'(1);
        end
      end
      ST_FRONT: begin
        wr        = '{we: 1'b1, addr: '0, data: req_r.item_type};
        state_nxt = ST_DONE;
      end
      ST_FSHIFT: begin
        raddr  = sh_r + IDX_W'(1);
        wr     = '{we: 1'b1, addr: sh_r, data: rdata};
        sh_nxt = sh_r + IDX_W'(1);
        if ((CNT_W'(sh_r) + CNT_W'(2)) >= cnt_r) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        // sh_r sits on the old tail here
        wr        = '{we: 1'b1, addr: sh_r, data: 8'd0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        done            = 1'b1;
        res.entry_total = 6'(cnt_r);
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    sh_r  <= sh_nxt;
  end

  `MTL_ASSERT(a_cnt_bound, (32'(cnt_r) <= LIST_DEPTH), "entry count above list depth")
  `MTL_ASSERT_IMPL(a_search_idx, (state_r == ST_SEARCH), (CNT_W'(idx_r) < cnt_r), "search past count")
  `MTL_ASSERT_IMPL(a_evict_full, (done && res.evicted_valid), (cnt_r == CNT_W'(LIST_DEPTH)), "eviction from a list that is not full")
  `MTL_ASSERT_IMPL(a_range_nochg, (done && (res.status != STATUS_OK)), (!res.changed && !req_oor == (res.status == STATUS_EMPTY)), "refused transaction marked as change")

endmodule
